// ===== hdl/dtrq_pkg.sv =====
// dtrq_pkg: shared types and constants for the duplicate-suppressing task ring queue
// holds the field widths, the status codes and the sequencer states
// used by dtrq_ring and dedup_task_ring_queue
`default_nettype none

package dtrq_pkg;

	localparam int DEF_QUEUE_SLOTS = 16;
	localparam int ID_W            = 16;
	localparam int STATUS_W        = 3;
	localparam int COUNT_W         = 4;
	localparam int COUNT_MAX       = 15;

	typedef enum logic [STATUS_W-1:0] {
		STAT_POSTED = 3'd0,
		STAT_DUP    = 3'd1,
		STAT_FULL   = 3'd2,
		STAT_POPPED = 3'd3,
		STAT_EMPTY  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_POP
	} seq_state_t;

	typedef enum logic {
		FUNC_POST = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

endpackage

`default_nettype wire

// ===== hdl/dtrq_ring.sv =====
// dtrq_ring: storage of the task ring, one write port and one registered read port
// the read port reads every cycle at the given address
// depends on dtrq_pkg for the identifier width and the default slot count
`default_nettype none

module dtrq_ring #(
	parameter int QUEUE_SLOTS = dtrq_pkg::DEF_QUEUE_SLOTS,
	localparam int IDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [IDX_W-1:0]          wr_addr,
	input  wire logic [dtrq_pkg::ID_W-1:0] wr_data,
	input  wire logic [IDX_W-1:0]          rd_addr,
	output logic      [dtrq_pkg::ID_W-1:0] rd_data
);

	logic [dtrq_pkg::ID_W-1:0] mem [QUEUE_SLOTS];
	logic [dtrq_pkg::ID_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/dedup_task_ring_queue.sv =====
// dedup_task_ring_queue: top level, sequencer and shared compare unit of the task ring queue
// depends on dtrq_pkg and dtrq_ring
//
// Usage:
//   A command is transferred at a rising edge with start high and busy low.
//   func selects post (0) or pop (1); task_id is the identifier to post.
//   busy stays high from the cycle after the transfer until the result is out.
//   Each command gives exactly one result: status, popped_id and pending_count
//   are valid for the single cycle in which done is high. The receiver cannot
//   stall; a result is gone after that cycle.
// Sequencing:
//   A post walks the pending entries oldest first, one ring read and one
//   compare a cycle through the single read port and the shared comparator.
//   With n tasks pending before it (at most QUEUE_SLOTS-1), the walk reads all n
//   entries before the post is taken or refused as full; a duplicate stops the
//   walk early. A pop passes through the SEQ_POP state and then raises done.
//   The next command may be transferred in the cycle done is high.
// Reset:
//   arst_n low empties the queue (head, tail and count zero) and idles the
//   sequencer. Ring contents are not cleared; only occupied entries are compared or popped.
`default_nettype none

module dedup_task_ring_queue #(
	parameter int QUEUE_SLOTS = dtrq_pkg::DEF_QUEUE_SLOTS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           func,
	input  wire logic [dtrq_pkg::ID_W-1:0]      task_id,
	output logic                                done,
	output logic      [dtrq_pkg::STATUS_W-1:0]  status,
	output logic      [dtrq_pkg::ID_W-1:0]      popped_id,
	output logic      [dtrq_pkg::COUNT_W-1:0]   pending_count
);

	localparam int IDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam int EXT_W = (IDX_W > dtrq_pkg::COUNT_W) ? IDX_W : dtrq_pkg::COUNT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_SLOTS - 1);

	dtrq_pkg::seq_state_t state_q, state_n;

	logic [IDX_W-1:0] head_q, head_n;
	logic [IDX_W-1:0] tail_q, tail_n;
	logic [IDX_W-1:0] cnt_q, cnt_n;
	logic [IDX_W-1:0] ptr_q, ptr_n;
	logic [IDX_W-1:0] left_q, left_n;
	logic             pend_q, pend_n;
	logic [dtrq_pkg::ID_W-1:0] id_q, id_n;

	logic                          done_q, done_n;
	logic [dtrq_pkg::STATUS_W-1:0] status_q, status_n;
	logic [dtrq_pkg::ID_W-1:0]     popped_q, popped_n;
	logic [dtrq_pkg::COUNT_W-1:0]  pcount_q, pcount_n;

	logic                      wr_en;
	logic [IDX_W-1:0]          rd_addr;
	logic [dtrq_pkg::ID_W-1:0] rd_data;
	logic                      id_match;
	logic                      finish;
	logic [EXT_W-1:0]          cnt_ext;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		ring_next = (i == LAST_IDX) ? '0 : i + IDX_W'(1);
	endfunction

	dtrq_ring #(
		.QUEUE_SLOTS(QUEUE_SLOTS)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data (id_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// shared compare unit
	assign id_match = (rd_data == id_q);
	assign rd_addr  = (state_q == dtrq_pkg::SEQ_SCAN) ? ptr_q : head_q;

	always_comb begin
		state_n  = state_q;
		head_n   = head_q;
		tail_n   = tail_q;
		cnt_n    = cnt_q;
		ptr_n    = ptr_q;
		left_n   = left_q;
		pend_n   = 1'b0;
		id_n     = id_q;
		status_n = status_q;
		popped_n = '0;
		finish   = 1'b0;
		wr_en    = 1'b0;
		case (state_q)
			dtrq_pkg::SEQ_IDLE: begin
				if (start) begin
					id_n   = task_id;
					ptr_n  = head_q;
					left_n = cnt_q;
					if (func == dtrq_pkg::FUNC_POP) begin
						state_n = dtrq_pkg::SEQ_POP;
					end else begin
						state_n = dtrq_pkg::SEQ_SCAN;
					end
				end
			end
			dtrq_pkg::SEQ_SCAN: begin
				if (left_q != '0) begin
					ptr_n  = ring_next(ptr_q);
					left_n = left_q - IDX_W'(1);
					pend_n = 1'b1;
				end
				if (pend_q && id_match) begin
					finish   = 1'b1;
					status_n = dtrq_pkg::STAT_DUP;
				end else if (left_q == '0 && !pend_q) begin
					finish = 1'b1;
					if (cnt_q == LAST_IDX) begin
						status_n = dtrq_pkg::STAT_FULL;
					end else begin
						wr_en    = 1'b1;
						tail_n   = ring_next(tail_q);
						cnt_n    = cnt_q + IDX_W'(1);
						status_n = dtrq_pkg::STAT_POSTED;
					end
				end
				if (finish) begin
					state_n = dtrq_pkg::SEQ_IDLE;
					pend_n  = 1'b0;
				end
			end
			dtrq_pkg::SEQ_POP: begin
				finish  = 1'b1;
				state_n = dtrq_pkg::SEQ_IDLE;
				if (cnt_q == '0) begin
					status_n = dtrq_pkg::STAT_EMPTY;
				end else begin
					popped_n = rd_data;
					head_n   = ring_next(head_q);
					cnt_n    = cnt_q - IDX_W'(1);
					status_n = dtrq_pkg::STAT_POPPED;
				end
			end
			default: begin
				state_n = dtrq_pkg::SEQ_IDLE;
			end
		endcase
		done_n = finish;
	end

	// saturate the count into the output field
	assign cnt_ext  = EXT_W'(cnt_n);
	assign pcount_n = (cnt_ext > EXT_W'(dtrq_pkg::COUNT_MAX)) ?
		dtrq_pkg::COUNT_W'(dtrq_pkg::COUNT_MAX) : cnt_ext[dtrq_pkg::COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtrq_pkg::SEQ_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			left_q  <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			head_q  <= head_n;
			tail_q  <= tail_n;
			cnt_q   <= cnt_n;
			left_q  <= left_n;
			pend_q  <= pend_n;
			done_q  <= done_n;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_n;
		id_q  <= id_n;
		if (finish) begin
			status_q <= status_n;
			popped_q <= popped_n;
			pcount_q <= pcount_n;
		end
	end

	assign busy          = (state_q != dtrq_pkg::SEQ_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign popped_id     = popped_q;
	assign pending_count = pcount_q;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench: checks dedup_task_ring_queue against a predictor of its ring, duplicate scan and counts
// a driver feeds post and pop commands from a queue; a monitor checks every done strobe
// depends on dtrq_pkg and dedup_task_ring_queue
`timescale 1ns / 100ps

module testbench;

	localparam int SLOTS = dtrq_pkg::DEF_QUEUE_SLOTS;

	typedef struct {
		bit                        drain;
		dtrq_pkg::func_t           op;
		logic [dtrq_pkg::ID_W-1:0] id;
	} command_t;

	typedef struct {
		dtrq_pkg::status_t            status;
		logic [dtrq_pkg::ID_W-1:0]    popped;
		logic [dtrq_pkg::COUNT_W-1:0] count;
	} outcome_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          func = dtrq_pkg::FUNC_POST;
	logic [dtrq_pkg::ID_W-1:0]     task_id = '0;
	logic                          busy;
	logic                          done;
	logic [dtrq_pkg::STATUS_W-1:0] status;
	logic [dtrq_pkg::ID_W-1:0]     popped_id;
	logic [dtrq_pkg::COUNT_W-1:0]  pending_count;

	command_t                  cmds_to_send[$];
	outcome_t                  outcomes_due[$];
	logic [dtrq_pkg::ID_W-1:0] pend_ids[SLOTS];
	int                        pend_head = 0;
	int                        pend_tail = 0;
	int                        n_sent = 0;
	int                        errors = 0;
	int                        tally[5];

	dedup_task_ring_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.task_id       (task_id),
		.done          (done),
		.status        (status),
		.popped_id     (popped_id),
		.pending_count (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// applies one command to the predicted ring and returns the result it gives
	function automatic outcome_t apply_command(input dtrq_pkg::func_t op,
		input logic [dtrq_pkg::ID_W-1:0] id);
		outcome_t r;
		int used;
		int k;
		bit hit;
		r.popped = '0;
		used = (pend_tail + SLOTS - pend_head) % SLOTS;
		hit = 1'b0;
		for (k = 0; k < used; k++)
			if (pend_ids[(pend_head + k) % SLOTS] == id)
				hit = 1'b1;
		if (op == dtrq_pkg::FUNC_POST) begin
			if (hit) begin
				r.status = dtrq_pkg::STAT_DUP;
			end else if ((pend_tail + 1) % SLOTS == pend_head) begin
				r.status = dtrq_pkg::STAT_FULL;
			end else begin
				pend_ids[pend_tail] = id;
				pend_tail = (pend_tail + 1) % SLOTS;
				r.status = dtrq_pkg::STAT_POSTED;
			end
		end else if (used == 0) begin
			r.status = dtrq_pkg::STAT_EMPTY;
		end else begin
			r.popped = pend_ids[pend_head];
			pend_head = (pend_head + 1) % SLOTS;
			r.status = dtrq_pkg::STAT_POPPED;
		end
		used = (pend_tail + SLOTS - pend_head) % SLOTS;
		r.count = dtrq_pkg::COUNT_W'(used > dtrq_pkg::COUNT_MAX ? dtrq_pkg::COUNT_MAX : used);
		return r;
	endfunction

	function automatic void queue_cmd(input bit drain, input dtrq_pkg::func_t op,
		input logic [dtrq_pkg::ID_W-1:0] id);
		command_t c;
		c.drain = drain;
		c.op = op;
		c.id = id;
		cmds_to_send.push_back(c);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		command_t nxt;
		bit xfer;
		bit idle_ok;
		if (!arst_n) begin
			start <= 1'b0;
			func <= dtrq_pkg::FUNC_POST;
			task_id <= '0;
		end else begin
			xfer = start && !busy;
			if (xfer) begin
				outcomes_due.push_back(apply_command(dtrq_pkg::func_t'(func), task_id));
				n_sent++;
			end
			// no random idling over a long stretch in the middle of the run
			idle_ok = !(n_sent >= 400 && n_sent < 750);
			if (start && !xfer) begin
				// hold the command until the transfer
			end else if (cmds_to_send.size() == 0) begin
				start <= 1'b0;
			end else if (cmds_to_send[0].drain) begin
				start <= 1'b0;
				if (!xfer && outcomes_due.size() == 0)
					cmds_to_send.delete(0);
			end else if (idle_ok && $urandom_range(99) < 12) begin
				start <= 1'b0;
			end else begin
				nxt = cmds_to_send.pop_front();
				start <= 1'b1;
				func <= nxt.op;
				task_id <= nxt.id;
			end
		end
	end

	// monitor, sampled mid-cycle while the result is stable
	always @(negedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (outcomes_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: status %0d popped_id %h pending_count %0d",
					$time, status, popped_id, pending_count);
			end else begin
				want = outcomes_due.pop_front();
				tally[want.status]++;
				if (status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
				end
				if (popped_id !== want.popped) begin
					errors++;
					$display("%0t: popped_id expected %h actual %h", $time, want.popped, popped_id);
				end
				if (pending_count !== want.count) begin
					errors++;
					$display("%0t: pending_count expected %0d actual %0d",
						$time, want.count, pending_count);
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("testbench failed");
		$finish;
	end

	initial begin
		int k;
		int post_pct;
		int pick;
		logic [dtrq_pkg::ID_W-1:0] v;

		// pop when empty, extreme ids, duplicates, pops down to empty
		queue_cmd(1'b0, dtrq_pkg::FUNC_POP, 16'hFFFF);
		queue_cmd(1'b0, dtrq_pkg::FUNC_POST, 16'h0000);
		queue_cmd(1'b0, dtrq_pkg::FUNC_POST, 16'hFFFF);
		queue_cmd(1'b0, dtrq_pkg::FUNC_POST, 16'hFFFF);
		queue_cmd(1'b0, dtrq_pkg::FUNC_POST, 16'h0000);
		queue_cmd(1'b0, dtrq_pkg::FUNC_POP, 16'h0000);
		queue_cmd(1'b0, dtrq_pkg::FUNC_POP, 16'hA5A5);
		queue_cmd(1'b0, dtrq_pkg::FUNC_POP, 16'h5A5A);
		// fill across the wrap point, then overflow and duplicates while full
		for (k = 0; k < SLOTS - 1; k++)
			queue_cmd(1'b0, dtrq_pkg::FUNC_POST, 16'h0100 + dtrq_pkg::ID_W'(k));
		queue_cmd(1'b0, dtrq_pkg::FUNC_POST, 16'h0200);
		queue_cmd(1'b0, dtrq_pkg::FUNC_POST, 16'h0100);
		queue_cmd(1'b0, dtrq_pkg::FUNC_POST, 16'h0100 + dtrq_pkg::ID_W'(SLOTS - 2));
		queue_cmd(1'b1, dtrq_pkg::FUNC_POST, '0);

		post_pct = 50;
		for (k = 0; k < 1250; k++) begin
			if (k % 50 == 0) begin
				pick = $urandom_range(2);
				post_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
			end
			if (k % 300 == 299)
				queue_cmd(1'b1, dtrq_pkg::FUNC_POST, '0);
			pick = $urandom_range(99);
			if (pick < 60)
				v = dtrq_pkg::ID_W'($urandom_range(19));
			else if (pick < 75)
				v = 16'hFFF0 | dtrq_pkg::ID_W'($urandom_range(15));
			else
				v = dtrq_pkg::ID_W'($urandom);
			if ($urandom_range(99) < post_pct)
				queue_cmd(1'b0, dtrq_pkg::FUNC_POST, v);
			else
				queue_cmd(1'b0, dtrq_pkg::FUNC_POP, dtrq_pkg::ID_W'($urandom));
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (cmds_to_send.size() != 0 || start || outcomes_due.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);

		$display("run: %0d commands; %0d posted, %0d duplicates ignored, %0d dropped when full",
			n_sent, tally[dtrq_pkg::STAT_POSTED], tally[dtrq_pkg::STAT_DUP],
			tally[dtrq_pkg::STAT_FULL]);
		$display("run: %0d popped, %0d pops from an empty queue",
			tally[dtrq_pkg::STAT_POPPED], tally[dtrq_pkg::STAT_EMPTY]);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/dtrq_pkg.sv
hdl/dtrq_ring.sv
hdl/dedup_task_ring_queue.sv
test/testbench.sv
